// ----- rtl/leg_jacobian_torque_velocity_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the leg Jacobian block
// Concurrent checks that compile to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef LEG_JACOBIAN_TORQUE_VELOCITY_DEFINES_SVH
`define LEG_JACOBIAN_TORQUE_VELOCITY_DEFINES_SVH
`ifndef SYNTHESIS
`define LJ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("lj check");
`define LJ_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("lj reset check");
`else
`define LJ_ASSERT(lbl, prop)
`define LJ_ASSERT_RST(lbl, prop)
`endif
`endif

// ----- rtl/ljtv_pkg.sv -----
// ---------------------------------------------------------------------------
// ljtv_pkg
// Types and constants shared by the leg Jacobian block.
// ---------------------------------------------------------------------------
package ljtv_pkg;
  localparam int unsigned AngW   = 26;
  localparam int unsigned TrigW  = 34;
  localparam int unsigned MaxSteps = 24;
  localparam logic signed [TrigW-1:0] CordicK = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_THIGH_OFF = 3'd0,
    REG_CALF_OFF  = 3'd1,
    REG_UPPER_LEN = 3'd2,
    REG_LOWER_LEN = 3'd3,
    REG_ROLL      = 3'd4,
    REG_FRONT     = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [TrigW-1:0] x;
    logic signed [TrigW-1:0] y;
    logic signed [AngW-1:0]  z;
    logic                    neg;
  } cordic_t;

  function automatic logic signed [AngW-1:0] atan_deg(input logic [4:0] i);
    unique case (i)
      5'd0:  atan_deg = 26'sd2949120;
      5'd1:  atan_deg = 26'sd1740967;
      5'd2:  atan_deg = 26'sd919879;
      5'd3:  atan_deg = 26'sd466945;
      5'd4:  atan_deg = 26'sd234379;
      5'd5:  atan_deg = 26'sd117304;
      5'd6:  atan_deg = 26'sd58666;
      5'd7:  atan_deg = 26'sd29335;
      5'd8:  atan_deg = 26'sd14668;
      5'd9:  atan_deg = 26'sd7334;
      5'd10: atan_deg = 26'sd3667;
      5'd11: atan_deg = 26'sd1833;
      5'd12: atan_deg = 26'sd917;
      5'd13: atan_deg = 26'sd458;
      5'd14: atan_deg = 26'sd229;
      5'd15: atan_deg = 26'sd115;
      5'd16: atan_deg = 26'sd57;
      5'd17: atan_deg = 26'sd29;
      5'd18: atan_deg = 26'sd14;
      5'd19: atan_deg = 26'sd7;
      5'd20: atan_deg = 26'sd4;
      5'd21: atan_deg = 26'sd2;
      5'd22: atan_deg = 26'sd1;
      default: atan_deg = 26'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction
endpackage

// ----- rtl/ljtv_cordic.sv -----
// ---------------------------------------------------------------------------
// ljtv_cordic
// Pipelined degree-domain CORDIC: one register stage per rotation step.
// ---------------------------------------------------------------------------
module ljtv_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           vld_i,
  input  logic signed [17:0]             ang_i,
  output logic                           vld_o,
  output logic signed [ljtv_pkg::TrigW-1:0] sin_o,
  output logic signed [ljtv_pkg::TrigW-1:0] cos_o
);
  import ljtv_pkg::*;
  localparam int unsigned N = (STEPS < MaxSteps) ? STEPS : MaxSteps;

  cordic_t        st_q [N+1];
  logic [N:0]     vld_q;
  cordic_t        st0_d;
  logic signed [17:0] r0, r1;

  always_comb begin
    // wrap to [-180,180) deg in three compare-and-subtract steps
    r0 = ang_i;
    if (r0 >= 18'sd80640) r0 = r0 - 18'sd92160;
    else if (r0 < -18'sd80640) r0 = r0 + 18'sd92160;
    if (r0 >= 18'sd34560) r0 = r0 - 18'sd46080;
    else if (r0 < -18'sd34560) r0 = r0 + 18'sd46080;
    if (r0 >= 18'sd11520) r0 = r0 - 18'sd23040;
    else if (r0 < -18'sd11520) r0 = r0 + 18'sd23040;
    r1 = r0;
    st0_d.neg = 1'b0;
    if (r0 > 18'sd5760) begin
      r1 = 18'sd11520 - r0;
      st0_d.neg = 1'b1;
    end else if (r0 < -18'sd5760) begin
      r1 = -18'sd11520 - r0;
      st0_d.neg = 1'b1;
    end
    st0_d.x = CordicK;
    st0_d.y = '0;
    st0_d.z = {{(AngW-18){r1[17]}}, r1} <<< 10;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else vld_q[0] <= vld_i;
  end
  always_ff @(posedge clk_i) st_q[0] <= st0_d;

  for (genvar i = 0; i < N; i++) begin : g_step
    cordic_t nx;
    always_comb begin
      nx = st_q[i];
      if (!st_q[i].z[AngW-1]) begin
        nx.x = st_q[i].x - (st_q[i].y >>> i);
        nx.y = st_q[i].y + (st_q[i].x >>> i);
        nx.z = st_q[i].z - atan_deg(5'(i));
      end else begin
        nx.x = st_q[i].x + (st_q[i].y >>> i);
        nx.y = st_q[i].y - (st_q[i].x >>> i);
        nx.z = st_q[i].z + atan_deg(5'(i));
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[i+1] <= 1'b0;
      else vld_q[i+1] <= vld_q[i];
    end
    always_ff @(posedge clk_i) st_q[i+1] <= nx;
  end

  assign vld_o = vld_q[N];
  assign sin_o = st_q[N].y;
  assign cos_o = st_q[N].neg ? -st_q[N].x : st_q[N].x;
endmodule

// ----- rtl/leg_jacobian_torque_velocity.sv -----
// ---------------------------------------------------------------------------
// leg_jacobian_torque_velocity
// Jacobian-transpose joint torques and foot velocity for one leg per word.
// ---------------------------------------------------------------------------
// Fully pipelined: a word may be started every cycle. The path is
// min(CORDIC_STEPS,24)+7 register stages deep: the CORDIC input register and
// one per rotation step, then link-product, link-rounding, Jacobian-product,
// Jacobian-rounding, force/speed-product and output registers. done_o is
// registered at the same edge as the result, so both are shown together.
// busy is always low and the result is shown for one cycle only, so the
// receiver must capture it when done_o is high.
`include "leg_jacobian_torque_velocity_defines.svh"
module leg_jacobian_torque_velocity #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         leg_i,
  input  logic signed [15:0] thigh_raw_i,
  input  logic signed [15:0] calf_raw_i,
  input  logic signed [15:0] thigh_speed_i,
  input  logic signed [15:0] calf_speed_i,
  input  logic signed [15:0] force_x_i,
  input  logic signed [15:0] force_y_i,
  input  logic signed [15:0] force_z_i,
  output logic               done_o,
  output logic [1:0]         leg_out_o,
  output logic signed [31:0] torque_roll_o,
  output logic signed [31:0] torque_thigh_o,
  output logic signed [31:0] torque_calf_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_z_o
);
  import ljtv_pkg::*;
  localparam int unsigned N = (CORDIC_STEPS < MaxSteps) ? CORDIC_STEPS : MaxSteps;
  localparam int unsigned D = N + 1;

  logic signed [15:0] thigh_off_q, calf_off_q, roll_q;
  logic [15:0]        l1_q, l2_q;
  logic [3:0]         front_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thigh_off_q <= '0;
      calf_off_q  <= '0;
      l1_q        <= 16'd11796;
      l2_q        <= 16'd11796;
      roll_q      <= '0;
      front_q     <= 4'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THIGH_OFF: thigh_off_q <= cfg_data_i;
        REG_CALF_OFF:  calf_off_q  <= cfg_data_i;
        REG_UPPER_LEN: l1_q        <= cfg_data_i;
        REG_LOWER_LEN: l2_q        <= cfg_data_i;
        REG_ROLL:      roll_q      <= cfg_data_i;
        REG_FRONT:     front_q     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic acc;
  assign acc = start && !busy;

  logic signed [17:0] a2, a23;
  assign a2  = 18'(thigh_off_q) - 18'(thigh_raw_i);
  assign a23 = a2 + 18'(calf_raw_i) - 18'(calf_off_q);

  logic v1, v2, v3;
  logic signed [TrigW-1:0] s1, c1, s2, c2, s23, c23;

  ljtv_cordic #(.STEPS(CORDIC_STEPS)) u_c1 (
    .clk_i, .rst_ni, .vld_i(acc), .ang_i(18'(roll_q)), .vld_o(v1), .sin_o(s1), .cos_o(c1));
  ljtv_cordic #(.STEPS(CORDIC_STEPS)) u_c2 (
    .clk_i, .rst_ni, .vld_i(acc), .ang_i(a2), .vld_o(v2), .sin_o(s2), .cos_o(c2));
  ljtv_cordic #(.STEPS(CORDIC_STEPS)) u_c3 (
    .clk_i, .rst_ni, .vld_i(acc), .ang_i(a23), .vld_o(v3), .sin_o(s23), .cos_o(c23));

  // Side-band delay line matching the CORDIC depth
  typedef struct packed {
    logic [1:0]         leg;
    logic               front;
    logic signed [15:0] w2, w3, fx, fy, fz;
  } side_t;
  side_t sb_q [D];
  side_t sb_in;
  always_comb begin
    sb_in.leg = leg_i;
    sb_in.front = front_q[leg_i];
    sb_in.w2 = thigh_speed_i;
    sb_in.w3 = calf_speed_i;
    sb_in.fx = force_x_i;
    sb_in.fy = force_y_i;
    sb_in.fz = force_z_i;
  end
  always_ff @(posedge clk_i) begin
    sb_q[0] <= sb_in;
    for (int i = 1; i < D; i++) sb_q[i] <= sb_q[i-1];
  end
  side_t sb;
  assign sb = sb_q[D-1];

  // Stage A: link products (Q46)
  logic va_q;
  side_t sa_q;
  logic signed [TrigW-1:0] s1a_q, c1a_q;
  logic signed [50:0] l1c2_q, l2c23_q, l1s2_q, l2s23_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else va_q <= v2;
  end
  always_ff @(posedge clk_i) begin
    sa_q   <= sb;
    s1a_q  <= s1;
    c1a_q  <= c1;
    l1c2_q  <= 51'(c2)  * $signed({1'b0, l1_q});
    l2c23_q <= 51'(c23) * $signed({1'b0, l2_q});
    l1s2_q  <= 51'(s2)  * $signed({1'b0, l1_q});
    l2s23_q <= 51'(s23) * $signed({1'b0, l2_q});
  end

  // Stage B: round to Q30 metres
  logic vb_q;
  side_t sbb_q;
  logic signed [TrigW-1:0] s1b_q, c1b_q;
  logic signed [35:0] p_q, q_q, r_q, s_q;
  logic signed [51:0] psum, qsum;
  assign psum = 52'(l1c2_q) + 52'(l2c23_q) + 52'sd32768;
  assign qsum = 52'(l1s2_q) + 52'(l2s23_q) + 52'sd32768;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else vb_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    sbb_q <= sa_q;
    s1b_q <= s1a_q;
    c1b_q <= c1a_q;
    p_q <= 36'(psum >>> 16);
    q_q <= 36'(qsum >>> 16);
    r_q <= 36'((52'(l2s23_q) + 52'sd32768) >>> 16);
    s_q <= 36'((52'(l2c23_q) + 52'sd32768) >>> 16);
  end

  // Stage C: trig times link term (Q60)
  logic vc_q;
  side_t sc_q;
  logic signed [35:0] pc_q, sc2_q;
  logic signed [70:0] m00_q, m01_q, m02_q, m20_q, m21_q, m22_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else vc_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    sc_q  <= sbb_q;
    pc_q  <= p_q;
    sc2_q <= s_q;
    m00_q <= 71'(c1b_q) * 71'(p_q);
    m01_q <= 71'(s1b_q) * 71'(q_q);
    m02_q <= 71'(s1b_q) * 71'(r_q);
    m20_q <= 71'(s1b_q) * 71'(p_q);
    m21_q <= 71'(c1b_q) * 71'(q_q);
    m22_q <= 71'(c1b_q) * 71'(r_q);
  end

  // Stage D: round to Jacobian entries
  function automatic logic signed [40:0] r30(input logic signed [70:0] v);
    logic signed [70:0] t;
    t = (v + 71'sd536870912) >>> 30;
    r30 = t[40:0];
  endfunction
  logic vd_q;
  side_t sd_q;
  logic signed [40:0] j00_q, j01_q, j02_q, j11_q, j12_q, j20_q, j21_q, j22_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else vd_q <= vc_q;
  end
  always_ff @(posedge clk_i) begin
    sd_q  <= sc_q;
    j00_q <= r30(m00_q);
    j01_q <= -r30(m01_q);
    j02_q <= -r30(m02_q);
    j11_q <= 41'(pc_q);
    j12_q <= 41'(sc2_q);
    j20_q <= r30(m20_q);
    j21_q <= r30(m21_q);
    j22_q <= r30(m22_q);
  end

  // Stage E: products with force and speed
  logic ve_q;
  logic [1:0] le_q;
  logic signed [56:0] e00, e20, e01, e11, e21, e02, e12, e22;
  logic signed [56:0] x2, x3, y2, y3, z2, z3;
  logic signed [16:0] w2s, w3s;
  assign w2s = sd_q.front ? 17'(sd_q.w2) : -17'(sd_q.w2);
  assign w3s = sd_q.front ? -17'(sd_q.w3) : 17'(sd_q.w3);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ve_q <= 1'b0;
    else ve_q <= vd_q;
  end
  always_ff @(posedge clk_i) begin
    le_q <= sd_q.leg;
    e00 <= 57'(j00_q) * 57'(sd_q.fx);
    e20 <= 57'(j20_q) * 57'(sd_q.fz);
    e01 <= 57'(j01_q) * 57'(sd_q.fx);
    e11 <= 57'(j11_q) * 57'(sd_q.fy);
    e21 <= 57'(j21_q) * 57'(sd_q.fz);
    e02 <= 57'(j02_q) * 57'(sd_q.fx);
    e12 <= 57'(j12_q) * 57'(sd_q.fy);
    e22 <= 57'(j22_q) * 57'(sd_q.fz);
    x2  <= 57'(j01_q) * 57'(sd_q.w2);
    x3  <= 57'(j02_q) * 57'(sd_q.w3);
    y2  <= 57'(j11_q) * 57'(w2s);
    y3  <= 57'(j12_q) * 57'(w3s);
    z2  <= 57'(j21_q) * 57'(sd_q.w2);
    z3  <= 57'(j22_q) * 57'(sd_q.w3);
  end

  // Stage F: sums, rounding and saturation
  logic signed [59:0] t0, t1, t2, u0, u1, u2;
  assign t0 = (-(60'(e00) + 60'(e20)) + 60'sd131072) >>> 18;
  assign t1 = (-(60'(e01) + 60'(e11) + 60'(e21)) + 60'sd131072) >>> 18;
  assign t2 = (-(60'(e02) + 60'(e12) + 60'(e22)) + 60'sd131072) >>> 18;
  assign u0 = (60'(x2) + 60'(x3) + 60'sd2097152) >>> 22;
  assign u1 = (60'(y2) + 60'(y3) + 60'sd2097152) >>> 22;
  assign u2 = (60'(z2) + 60'(z3) + 60'sd2097152) >>> 22;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= ve_q;
  end
  always_ff @(posedge clk_i) begin
    leg_out_o      <= le_q;
    torque_roll_o  <= sat32(64'(t0));
    torque_thigh_o <= sat32(64'(t1));
    torque_calf_o  <= sat32(64'(t2));
    vel_x_o        <= sat32(64'(u0));
    vel_y_o        <= sat32(64'(u1));
    vel_z_o        <= sat32(64'(u2));
  end

  `LJ_ASSERT(a_cordic_aligned, (v1 == v2) && (v2 == v3))
  `LJ_ASSERT(a_start_reaches_out, acc |-> ##(D + 6) done_o)
  `LJ_ASSERT(a_no_spurious_done, done_o |-> $past(ve_q))
  `LJ_ASSERT_RST(a_reset_quiet, !rst_ni |=> !vd_q || !rst_ni)
endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Leg Jacobian torque and velocity bench
// Drives leg words with random gaps, predicts the joint torques and foot
// velocity with a local fixed-point CORDIC model and checks every result.
// ---------------------------------------------------------------------------
module testbench;
  import ljtv_pkg::*;

  localparam int unsigned Steps   = 16;
  localparam int unsigned Latency = Steps + 7;
  localparam int unsigned Limit   = 2000;

  typedef struct packed {
    logic [1:0]         leg;
    logic signed [31:0] t_roll;
    logic signed [31:0] t_thigh;
    logic signed [31:0] t_calf;
    logic signed [31:0] v_x;
    logic signed [31:0] v_y;
    logic signed [31:0] v_z;
  } leg_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] leg_i = '0;
  logic signed [15:0] thigh_raw_i = '0, calf_raw_i = '0, thigh_speed_i = '0;
  logic signed [15:0] calf_speed_i = '0, force_x_i = '0, force_y_i = '0;
  logic signed [15:0] force_z_i = '0;
  logic done_o;
  logic [1:0] leg_out_o;
  logic signed [31:0] torque_roll_o, torque_thigh_o, torque_calf_o;
  logic signed [31:0] vel_x_o, vel_y_o, vel_z_o;

  leg_jacobian_torque_velocity #(.CORDIC_STEPS(Steps)) u_dut (.*);

  always #1 clk_i = ~clk_i;

  logic signed [15:0] thigh_off_q, calf_off_q, roll_q;
  logic [15:0] upper_len_q, lower_len_q;
  logic [3:0] front_mask_q;
  leg_res_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint atan_step(int i);
    longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
    return tbl[i];
  endfunction

  task automatic sin_cos(input longint u, output longint sn, output longint cs);
    longint r, x, y, z, dx, dy;
    bit flip;
    r = u % 23040;
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (r < 0) r += 23040;
    if (r >= 11520) r -= 23040;
    if (r > 5760) begin
      r = 11520 - r;
      flip = 1'b1;
    end else if (r < -5760) begin
      r = -11520 - r;
      flip = 1'b1;
    end
    z = r * 1024;
    for (int i = 0; i < Steps && i < 24; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    sn = y;
    cs = flip ? -x : x;
  endtask

  task automatic predict_leg(input logic [1:0] leg, input logic signed [15:0] th,
                             input logic signed [15:0] ca, input logic signed [15:0] w2,
                             input logic signed [15:0] w3, input logic signed [15:0] fx,
                             input logic signed [15:0] fy, input logic signed [15:0] fz);
    longint a2, a3, l1, l2, s1, c1, s2, c2, s23, c23, p, q, r, s;
    longint j00, j01, j02, j20, j21, j22, st, sc;
    leg_res_t res;
    a2 = longint'(thigh_off_q) - longint'(th);
    a3 = longint'(ca) - longint'(calf_off_q);
    l1 = longint'(upper_len_q);
    l2 = longint'(lower_len_q);
    sin_cos(longint'(roll_q), s1, c1);
    sin_cos(a2, s2, c2);
    sin_cos(a2 + a3, s23, c23);
    p = rnd(l1 * c2 + l2 * c23, 16);
    q = rnd(l1 * s2 + l2 * s23, 16);
    r = rnd(l2 * s23, 16);
    s = rnd(l2 * c23, 16);
    j00 = rnd(c1 * p, 30);
    j01 = -rnd(s1 * q, 30);
    j02 = -rnd(s1 * r, 30);
    j20 = rnd(s1 * p, 30);
    j21 = rnd(c1 * q, 30);
    j22 = rnd(c1 * r, 30);
    st = front_mask_q[leg] ? 1 : -1;
    sc = -st;
    res.leg = leg;
    res.t_roll = clip32(rnd(-(j00 * fx + j20 * fz), 18));
    res.t_thigh = clip32(rnd(-(j01 * fx + p * fy + j21 * fz), 18));
    res.t_calf = clip32(rnd(-(j02 * fx + s * fy + j22 * fz), 18));
    res.v_x = clip32(rnd(j01 * w2 + j02 * w3, 22));
    res.v_y = clip32(rnd(p * st * w2 + s * sc * w3, 22));
    res.v_z = clip32(rnd(j21 * w2 + j22 * w3, 22));
    expected_q.push_back(res);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_THIGH_OFF: thigh_off_q = val;
      REG_CALF_OFF:  calf_off_q = val;
      REG_UPPER_LEN: upper_len_q = val;
      REG_LOWER_LEN: lower_len_q = val;
      REG_ROLL:      roll_q = val;
      REG_FRONT:     front_mask_q = val[3:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // sends one word; stays in the clock cycle after acceptance
  task automatic send_word(input logic [1:0] leg, input logic signed [15:0] th,
                           input logic signed [15:0] ca, input logic signed [15:0] w2,
                           input logic signed [15:0] w3, input logic signed [15:0] fx,
                           input logic signed [15:0] fy, input logic signed [15:0] fz);
    if (!no_gaps && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    leg_i <= leg; thigh_raw_i <= th; calf_raw_i <= ca;
    thigh_speed_i <= w2; calf_speed_i <= w3;
    force_x_i <= fx; force_y_i <= fy; force_z_i <= fz;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_leg(leg, th, ca, w2, w3, fx, fy, fz);
  endtask

  task automatic send_random();
    send_word(2'($urandom_range(3)), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic stop_words();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_extremes();
    logic signed [15:0] ext[4] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    for (int i = 0; i < 4; i++)
      send_word(i[1:0], ext[i], ext[3 - i], ext[i], ext[(i + 1) % 4],
                ext[i], ext[(i + 2) % 4], ext[(i + 3) % 4]);
    // whole-turn wraps and right-angle folds
    send_word(2'd0, 16'sd23040, -16'sd11520, 16'sd256, -16'sd256, 16'sd160, 16'sd0, -16'sd1600);
    send_word(2'd1, -16'sd5760, 16'sd5761, 16'sd1000, 16'sd1000, 16'sd0, 16'sd160, 16'sd0);
    send_word(2'd2, 16'sd5760, -16'sd5761, -16'sd1000, 16'sd500, 16'sd1, 16'sd1, 16'sd1);
    send_word(2'd3, 16'sd11520, 16'sd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    stop_words();
    drain();
  endtask

  task automatic test_settings();
    write_reg(REG_THIGH_OFF, 16'h8000);
    write_reg(REG_CALF_OFF, 16'h7fff);
    write_reg(REG_UPPER_LEN, 16'hffff);
    write_reg(REG_LOWER_LEN, 16'hffff);
    write_reg(REG_ROLL, 16'sd5760);
    write_reg(REG_FRONT, 16'h000a);
    for (int i = 0; i < 8; i++) send_random();
    stop_words();
    drain();
    write_reg(REG_THIGH_OFF, 16'h7fff);
    write_reg(REG_CALF_OFF, 16'h8000);
    write_reg(REG_UPPER_LEN, 16'h0000);
    write_reg(REG_LOWER_LEN, 16'h0001);
    write_reg(REG_ROLL, 16'h8000);
    write_reg(REG_FRONT, 16'h0005);
    for (int i = 0; i < 8; i++) send_random();
    stop_words();
    drain();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_THIGH_OFF, 16'($urandom));
      write_reg(REG_CALF_OFF, 16'($urandom));
      write_reg(REG_UPPER_LEN, 16'($urandom));
      write_reg(REG_LOWER_LEN, 16'($urandom));
      write_reg(REG_ROLL, 16'($urandom));
      write_reg(REG_FRONT, 16'($urandom));
      if (phase == 5) no_gaps = 1'b1;
      for (int i = 0; i < 200; i++) send_random();
      stop_words();
      drain();
    end
  endtask

  always @(posedge clk_i) begin
    leg_res_t want;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        report("unexpected result word", leg_out_o, 0);
      end else begin
        want = expected_q.pop_front();
        if (leg_out_o !== want.leg) report("leg", leg_out_o, want.leg);
        if (torque_roll_o !== want.t_roll) report("torque_roll", torque_roll_o, want.t_roll);
        if (torque_thigh_o !== want.t_thigh)
          report("torque_thigh", torque_thigh_o, want.t_thigh);
        if (torque_calf_o !== want.t_calf) report("torque_calf", torque_calf_o, want.t_calf);
        if (vel_x_o !== want.v_x) report("vel_x", vel_x_o, want.v_x);
        if (vel_y_o !== want.v_y) report("vel_y", vel_y_o, want.v_y);
        if (vel_z_o !== want.v_z) report("vel_z", vel_z_o, want.v_z);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > Limit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    thigh_off_q = 0; calf_off_q = 0; roll_q = 0;
    upper_len_q = 16'd11796; lower_len_q = 16'd11796; front_mask_q = 4'd3;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_settings();
    test_random();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
